// ----- rtl/rpsti_pkg.sv -----
// ---------------------------------------------------------------------------
// rpsti_pkg: shared types and helpers for the radix-prefix string parser
// Character codes, radix encoding, stage and digit types, digit decode, Horner multiply.
// ---------------------------------------------------------------------------
`default_nettype none

package rpsti_pkg;

    localparam int CHAR_WIDTH  = 8;
    localparam int VALUE_WIDTH = 64;
    localparam int ACC_WIDTH   = 64;   // accumulator width, 8..64

    localparam logic [CHAR_WIDTH-1:0] CHAR_NUL     = 8'h00;
    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 8'h30;  // '0'
    localparam logic [CHAR_WIDTH-1:0] CHAR_NINE    = 8'h39;  // '9'
    localparam logic [CHAR_WIDTH-1:0] CHAR_LC_A    = 8'h61;  // 'a'
    localparam logic [CHAR_WIDTH-1:0] CHAR_LC_F    = 8'h66;  // 'f'
    localparam logic [CHAR_WIDTH-1:0] CHAR_UC_A    = 8'h41;  // 'A'
    localparam logic [CHAR_WIDTH-1:0] CHAR_UC_F    = 8'h46;  // 'F'
    localparam logic [CHAR_WIDTH-1:0] CHAR_PFX_HEX = 8'h78;  // 'x'
    localparam logic [CHAR_WIDTH-1:0] CHAR_PFX_BIN = 8'h62;  // 'b'
    localparam logic [CHAR_WIDTH-1:0] CHAR_PFX_OCT = 8'h6f;  // 'o'

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_HEX = 2'd1,
        RADIX_BIN = 2'd2,
        RADIX_OCT = 2'd3
    } radix_t;

    typedef logic [ACC_WIDTH-1:0] acc_t;

    // Character held in the input register.
    typedef struct packed {
        logic                  valid;
        logic [CHAR_WIDTH-1:0] char_code;
    } stage_t;

    typedef struct packed {
        logic       is_digit;
        logic [3:0] val;
    } digit_t;

    function automatic digit_t digit_of(input logic [CHAR_WIDTH-1:0] c);
        digit_t d;
        d.is_digit = 1'b1;
        d.val      = 4'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d.val = 4'(c - CHAR_ZERO);
        end else if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
            d.val = 4'(c - CHAR_LC_A) + 4'd10;
        end else if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
            d.val = 4'(c - CHAR_UC_A) + 4'd10;
        end else begin
            d.is_digit = 1'b0;
        end
        return d;
    endfunction

    // acc * base by shifts; decimal is 8x + 2x.
    function automatic acc_t mul_radix(input acc_t acc, input radix_t radix);
        acc_t r;
        case (radix)
            RADIX_HEX: r = acc << 4;
            RADIX_BIN: r = acc << 1;
            RADIX_OCT: r = acc << 3;
            default:   r = (acc << 3) + (acc << 1);
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rpsti_if.sv -----
// ---------------------------------------------------------------------------
// rpsti_char_if / rpsti_value_if: valid-ready channels of the parser
// Character stream in, parsed value out.
// ---------------------------------------------------------------------------
`default_nettype none

interface rpsti_char_if;
    import rpsti_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CHAR_WIDTH-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface rpsti_value_if;
    import rpsti_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ----- rtl/radix_prefix_string_to_integer.sv -----
// ---------------------------------------------------------------------------
// radix_prefix_string_to_integer: streaming string-to-integer converter
// Parses characters with an optional 0x / 0b / 0o prefix into a 64-bit value.
// ---------------------------------------------------------------------------
// Usage:
//   chars  : valid/ready channel, one character per transaction. A NUL
//            character ends the string and produces one transaction on
//            result; every other character produces none.
//   result : valid/ready channel carrying the parsed value, modulo 2^64.
//   A leading lower-case "0x", "0b" or "0o" selects base 16, 2 or 8,
//   otherwise base 10. Digits 0-9, a-f, A-F are taken at face value even
//   when not below the base; all other characters are skipped.
// Timing:
//   One character per cycle, sustained, except while a NUL waits on an
//   untaken result (see Stall). A character is held in the input register
//   and folded into the accumulator as it leaves it (shift-add Horner step,
//   no multiplier); a NUL leaving it moves the value into the result register.
// Reset:
//   rst_n clears both registers' valid flags and returns the parser to
//   string start, decimal, accumulator zero.
// Stall:
//   While result holds an untaken value, ordinary characters keep flowing;
//   only a second NUL waits in the input register, and chars.ready drops
//   until result is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module radix_prefix_string_to_integer
    import rpsti_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    rpsti_char_if.sink    chars,
    rpsti_value_if.source result
);

    stage_t stage;    // input register contents
    logic   advance;  // core consumes the held character this cycle

    rpsti_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars),
        .advance (advance),
        .stage   (stage)
    );

    rpsti_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .stage   (stage),
        .advance (advance),
        .result  (result)
    );

endmodule

`default_nettype wire

// ----- rtl/rpsti_in_stage.sv -----
// ---------------------------------------------------------------------------
// rpsti_in_stage: input register of the parser
// Holds one character until the core consumes it.
// ---------------------------------------------------------------------------
`default_nettype none

module rpsti_in_stage
    import rpsti_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    rpsti_char_if.sink   chars,
    input  wire logic    advance,
    output stage_t       stage
);

    logic                  s1_valid_reg, s1_valid_next;
    logic [CHAR_WIDTH-1:0] s1_char_reg;
    logic                  take;

    // Empty, or draining this cycle.
    assign chars.ready = !s1_valid_reg || advance;
    assign take        = chars.valid && chars.ready;

    always_comb
    begin
        if (take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_char_reg <= chars.char_code;
        end
    end

    assign stage = {s1_valid_reg, s1_char_reg};

endmodule

`default_nettype wire

// ----- rtl/rpsti_core.sv -----
// ---------------------------------------------------------------------------
// rpsti_core: prefix tracking, Horner accumulate and result register
// One character per cycle unless a NUL waits on an untaken result; NUL moves the value to the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module rpsti_core
    import rpsti_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire stage_t   stage,
    output logic          advance,
    rpsti_value_if.source result
);

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_ZERO  = 2'd1,
        PH_BODY  = 2'd2
    } phase_t;

    phase_t phase_reg,  phase_next;
    radix_t radix_reg,  radix_next;
    acc_t   acc_reg,    acc_next;
    logic   out_valid_reg, out_valid_next;
    logic [VALUE_WIDTH-1:0] out_value_reg;

    logic   is_nul;
    logic   load_out;
    digit_t dig;
    acc_t   acc_step;

    assign is_nul   = (stage.char_code == CHAR_NUL);
    assign advance  = stage.valid && (!is_nul || !out_valid_reg || result.ready);
    assign load_out = advance && is_nul;

    assign dig      = digit_of(stage.char_code);
    assign acc_step = mul_radix(acc_reg, radix_reg) + acc_t'(dig.val);

    always_comb
    begin
        phase_next = phase_reg;
        radix_next = radix_reg;
        acc_next   = acc_reg;
        if (advance)
        begin
            if (is_nul)
            begin
                phase_next = PH_START;
                radix_next = RADIX_DEC;
                acc_next   = '0;
            end
            else
            begin
                if (dig.is_digit)
                begin
                    acc_next = acc_step;
                end
                case (phase_reg)
                    PH_START:
                    begin
                        phase_next = (stage.char_code == CHAR_ZERO) ? PH_ZERO : PH_BODY;
                    end
                    PH_ZERO:
                    begin
                        phase_next = PH_BODY;
                        // prefix letter wins over 'b' as a hex digit
                        if (stage.char_code == CHAR_PFX_HEX)
                        begin
                            radix_next = RADIX_HEX;
                            acc_next   = '0;
                        end
                        else if (stage.char_code == CHAR_PFX_BIN)
                        begin
                            radix_next = RADIX_BIN;
                            acc_next   = '0;
                        end
                        else if (stage.char_code == CHAR_PFX_OCT)
                        begin
                            radix_next = RADIX_OCT;
                            acc_next   = '0;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_BODY;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            radix_reg     <= RADIX_DEC;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            radix_reg     <= radix_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_value_reg <= VALUE_WIDTH'(acc_reg);
        end
    end

    assign result.valid = out_valid_reg;
    assign result.value = out_value_reg;

endmodule

`default_nettype wire

// ----- rtl/rpsti_checker.sv -----
// ---------------------------------------------------------------------------
// rpsti_checker: port-level checks for the string parser
// Output hold rules, stall source and reset behavior.
// ---------------------------------------------------------------------------
`default_nettype none

module rpsti_checker
    import rpsti_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_ready,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire logic [VALUE_WIDTH-1:0] out_value
);

    // A stalled result transaction stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_value))
        else $error("result value changed while stalled");

    // The only back-pressure source is an untaken result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("chars stalled without a pending result");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind radix_prefix_string_to_integer rpsti_checker u_rpsti_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (chars.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_value (result.value)
);

`default_nettype wire

// ----- dv/parsed_value_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// parsed_value_checker: scoreboard for the radix-prefix string parser
// Watches the character and value channels, predicts each parsed value and
// compares it with the value the block returns.
// ---------------------------------------------------------------------------

module parsed_value_checker
    import rpsti_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   char_valid,
    input  wire logic                   char_ready,
    input  wire logic [CHAR_WIDTH-1:0]  char_code,
    input  wire logic                   value_valid,
    input  wire logic                   value_ready,
    input  wire logic [VALUE_WIDTH-1:0] value,
    output int unsigned                 error_count,
    output int unsigned                 values_pending
);

    typedef enum logic [1:0] {
        AT_START   = 2'd0,
        AFTER_ZERO = 2'd1,
        IN_BODY    = 2'd2
    } scan_phase_t;

    scan_phase_t            scan_q;
    radix_t                 radix_q;
    acc_t                   acc_q;
    logic [VALUE_WIDTH-1:0] expected_values[$];
    logic [VALUE_WIDTH-1:0] oldest_value;
    int unsigned            mismatches = 0;
    int unsigned            queued     = 0;

    assign error_count    = mismatches;
    assign values_pending = queued;

    // -1 when the character is not a digit.
    function automatic int digit_value(input logic [CHAR_WIDTH-1:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
        if (c >= CHAR_LC_A && c <= CHAR_LC_F) return int'(c - CHAR_LC_A) + 10;
        if (c >= CHAR_UC_A && c <= CHAR_UC_F) return int'(c - CHAR_UC_A) + 10;
        return -1;
    endfunction

    function automatic acc_t base_of(input radix_t r);
        case (r)
            RADIX_HEX: return acc_t'(16);
            RADIX_BIN: return acc_t'(2);
            RADIX_OCT: return acc_t'(8);
            default:   return acc_t'(10);
        endcase
    endfunction

    // Horner step, wraps at the accumulator width.
    task automatic add_digit(input logic [CHAR_WIDTH-1:0] c);
        int d;
        d = digit_value(c);
        if (d >= 0) acc_q = acc_q * base_of(radix_q) + acc_t'(d);
    endtask

    task automatic fold_char(input logic [CHAR_WIDTH-1:0] c);
        if (c == CHAR_NUL) begin
            expected_values.push_back(VALUE_WIDTH'(acc_q));
            scan_q  = AT_START;
            radix_q = RADIX_DEC;
            acc_q   = '0;
        end else if (scan_q == AT_START) begin
            scan_q = (c == CHAR_ZERO) ? AFTER_ZERO : IN_BODY;
            add_digit(c);
        end else if (scan_q == AFTER_ZERO) begin
            // only the second character can be a prefix letter
            scan_q = IN_BODY;
            case (c)
                CHAR_PFX_HEX: begin radix_q = RADIX_HEX; acc_q = '0; end
                CHAR_PFX_BIN: begin radix_q = RADIX_BIN; acc_q = '0; end
                CHAR_PFX_OCT: begin radix_q = RADIX_OCT; acc_q = '0; end
                default:      add_digit(c);
            endcase
        end else begin
            add_digit(c);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            scan_q  = AT_START;
            radix_q = RADIX_DEC;
            acc_q   = '0;
            expected_values.delete();
            queued  = 0;
        end else begin
            // a value leaving now belongs to an earlier terminator
            if (value_valid && value_ready) begin
                if (expected_values.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected value %h", $realtime, value);
                end else begin
                    oldest_value = expected_values.pop_front();
                    if (value !== oldest_value) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: value mismatch, expected %h, actual %h",
                                     $realtime, oldest_value, value);
                    end
                end
            end
            if (char_valid && char_ready) fold_char(char_code);
            queued = expected_values.size();
        end
    end

endmodule

// ----- dv/tb_radix_prefix_string_to_integer.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_radix_prefix_string_to_integer: testbench for the string parser
// Feeds strings one character per transaction: a short directed set of
// corner cases, then random strings under several idle and stall patterns,
// including one long stall on the value side. A checker beside the block
// predicts every parsed value and counts mismatches.
// ---------------------------------------------------------------------------

module tb_radix_prefix_string_to_integer;

    import rpsti_pkg::*;

    // Cycles with no transaction on either channel before giving up. The
    // longest legitimate quiet stretch is the value-side hold-off below.
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned HOLD_OFF_LEN   = 300;
    localparam int unsigned PHASE_ITEMS    = 320;
    localparam int unsigned DRAIN_CYCLES   = 20;

    localparam string DEC_DIGITS = "0123456789";
    localparam string HEX_DIGITS = "0123456789abcdefABCDEF";
    localparam string BIN_DIGITS = "01";
    localparam string OCT_DIGITS = "01234567";

    logic        clk = 1'b0;
    logic        rst_n;

    int unsigned src_idle_pct  = 0;   // chance per cycle the sender sits idle
    int unsigned snk_stall_pct = 0;   // chance per cycle the receiver stalls
    int unsigned hold_cycles   = 0;   // pending long receiver hold-off
    int unsigned items_sent    = 0;   // character transactions
    int unsigned quiet_cycles  = 0;

    int unsigned error_count;
    int unsigned values_pending;

    rpsti_char_if  chars_if ();
    rpsti_value_if result_if ();

    radix_prefix_string_to_integer u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .result (result_if)
    );

    parsed_value_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .char_valid     (chars_if.valid),
        .char_ready     (chars_if.ready),
        .char_code      (chars_if.char_code),
        .value_valid    (result_if.valid),
        .value_ready    (result_if.ready),
        .value          (result_if.value),
        .error_count    (error_count),
        .values_pending (values_pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver. Stalls at random, or holds ready low for a whole hold-off
    // window when the stimulus asks for one. The window is counted here so
    // the sender keeps pushing characters meanwhile; once a second
    // terminator arrives the block has nowhere to put it and must stall
    // the character channel.
    initial
    begin
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles != 0)
            begin
                result_if.ready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                result_if.ready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    // Watchdog: a hang shows up as a long run of cycles with no transaction.
    always @(posedge clk)
    begin
        if (!rst_n || (chars_if.valid && chars_if.ready)
                   || (result_if.valid && result_if.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic logic [CHAR_WIDTH-1:0] pick_from(input string s);
        return s[$urandom_range(s.len() - 1)];
    endfunction

    // One character transaction. Always entered and left at a falling edge,
    // so valid gets exactly one update per edge and back-to-back characters
    // keep valid high.
    task automatic send_char(input logic [CHAR_WIDTH-1:0] c);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            chars_if.valid <= 1'b0;
            @(negedge clk);
        end
        chars_if.valid     <= 1'b1;
        chars_if.char_code <= c;
        do @(posedge clk); while (!chars_if.ready);
        @(negedge clk);
        items_sent++;
    endtask

    // A literal string followed by its terminator.
    task automatic send_text(input string s);
        foreach (s[i]) send_char(s[i]);
        send_char(CHAR_NUL);
    endtask

    // Mostly well-formed numbers with a random prefix and random digits,
    // sprinkled with out-of-base digits and junk; the rest is pure noise.
    // About one well-formed string in ten may run to 40 digits, enough to wrap the decimal, hex or octal accumulator.
    task automatic send_random_string();
        int unsigned len;
        string       digits;
        if ($urandom_range(99) < 75)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(10);
            case ($urandom_range(3))
                0: digits = DEC_DIGITS;
                1:
                begin
                    send_char(CHAR_ZERO);
                    send_char(CHAR_PFX_HEX);
                    digits = HEX_DIGITS;
                end
                2:
                begin
                    send_char(CHAR_ZERO);
                    send_char(CHAR_PFX_BIN);
                    digits = BIN_DIGITS;
                end
                default:
                begin
                    send_char(CHAR_ZERO);
                    send_char(CHAR_PFX_OCT);
                    digits = OCT_DIGITS;
                end
            endcase
            repeat (len)
            begin
                if ($urandom_range(15) == 0)
                    send_char(CHAR_WIDTH'($urandom_range(1, 255)));
                else if ($urandom_range(15) == 0)
                    send_char(pick_from(HEX_DIGITS));
                else
                    send_char(pick_from(digits));
            end
        end
        else
        begin
            // leading zero then garbage probes the prefix slot
            if ($urandom_range(1) == 0) send_char(CHAR_ZERO);
            repeat ($urandom_range(8)) send_char(CHAR_WIDTH'($urandom_range(1, 255)));
        end
        send_char(CHAR_NUL);
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned target;
        target = items_sent + count;
        while (items_sent < target) send_random_string();
    endtask

    initial
    begin
        rst_n              = 1'b1;
        chars_if.valid     = 1'b0;
        chars_if.char_code = CHAR_NUL;
        // assert reset off the zero time step so every reset edge is seen
        #1 rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed corner cases, back to back.
        send_char(CHAR_NUL);          // empty string
        send_text("0x");              // prefix alone
        send_text("0");               // bare zero
        send_text("0bb1");            // 'b' is prefix first, then digit eleven
        send_text("_0x1");            // junk first: no prefix, x skipped
        send_text("0o9F");            // digits above the base taken at face value
        send_char(8'hFF);             // top code point, ignored at start
        send_text("0A");              // zero then an ordinary digit

        run_random(PHASE_ITEMS);

        src_idle_pct = 78;
        run_random(PHASE_ITEMS);

        src_idle_pct  = 0;
        snk_stall_pct = 78;
        run_random(PHASE_ITEMS);

        src_idle_pct  = 30;
        snk_stall_pct = 30;
        run_random(PHASE_ITEMS);

        // Long receiver hold-off with the sender running flat out.
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_cycles   = HOLD_OFF_LEN;
        run_random(PHASE_ITEMS);

        chars_if.valid <= 1'b0;

        // Drain, then give a late or extra value time to show up.
        while (values_pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (error_count == 0 && values_pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/rpsti_pkg.sv
rtl/rpsti_if.sv
rtl/rpsti_in_stage.sv
rtl/rpsti_core.sv
rtl/radix_prefix_string_to_integer.sv
rtl/rpsti_checker.sv
dv/parsed_value_checker.sv
dv/tb_radix_prefix_string_to_integer.sv
